// File: hw/rtl/rpf_pkg.sv
// Shared types, register indexes and the CRC-16 byte update for the packet framer.
// Used by the front end, back end and top level of the framer; depends on nothing.
package rpf_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] status_byte;
      logic [7:0] byte_count;
      logic [7:0] packet_id;
      logic [7:0] payload_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
      logic       packet_end;
   } rsp_item_type;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREAMBLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STUFF    = 2'd2;

   localparam logic [7:0]  PREAMBLE_RESET = 8'hAA;
   localparam logic [15:0] SYNC_RESET     = 16'h2DD4;
   localparam logic [7:0]  STUFF_RESET    = 8'hAA;
   localparam logic [15:0] CRC_POLY       = 16'h8408;

   typedef struct packed {
      logic [7:0]  preamble_byte;
      logic [15:0] sync_word;
      logic [7:0]  stuff_byte;
   } cfg_type;

   typedef enum logic {
      CMD_START,
      CMD_DATA
   } cmd_op_type;

   // One queued command: a packet start or one payload byte, plus whether
   // the trailer follows it.
   typedef struct packed {
      cmd_op_type op;
      logic [7:0] status_byte;
      logic [7:0] byte_count;
      logic [7:0] packet_id;
      logic [7:0] payload_byte;
      logic       trailer;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_PRE0,
      PH_PRE1,
      PH_PRE2,
      PH_SYNC_HI,
      PH_SYNC_LO,
      PH_STATUS,
      PH_COUNT,
      PH_ID,
      PH_PAYLOAD,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_ZERO0,
      PH_ZERO1
   } phase_type;

   // Reflected CCITT update, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/rpf_fifo.sv
// Small register FIFO with first-word fall-through read.
// Generic; no package dependency.
module rpf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: hw/rtl/rpf_front.sv
// Front end: accepts items, tracks the open packet and byte count, and queues commands.
// Depends on rpf_pkg.
module rpf_front
   import rpf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   output logic         cmd_push,
   output cmd_type      cmd
);

   logic       open_ff, open_in;
   logic [7:0] left_ff, left_in;
   logic       last_data;

   assign last_data = (left_ff == 8'd1);

   always_comb begin
      open_in          = open_ff;
      left_in          = left_ff;
      cmd_push         = 1'b0;
      cmd.status_byte  = item.status_byte;
      cmd.byte_count   = item.byte_count;
      cmd.packet_id    = item.packet_id;
      cmd.payload_byte = item.payload_byte;
      cmd.op           = CMD_DATA;
      cmd.trailer      = 1'b0;
      if (item.kind == KIND_START) begin
         // a start abandons any open packet
         cmd.op      = CMD_START;
         cmd.trailer = (item.byte_count == 8'd0);
         if (accept) begin
            cmd_push = 1'b1;
            open_in  = (item.byte_count != 8'd0);
            left_in  = item.byte_count;
         end
      end else begin
         cmd.trailer = last_data;
         if (accept && open_ff) begin
            cmd_push = 1'b1;
            left_in  = left_ff - 8'd1;
            open_in  = !last_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

endmodule

// File: hw/rtl/rpf_back.sv
// Back end: expands queued commands into line bytes with stuffing, keeps the running CRC.
// Depends on rpf_pkg.
module rpf_back
   import rpf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cmd_empty,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   input  logic         out_full,
   output logic         out_push,
   output rsp_item_type out_item
);

   logic        busy_ff, busy_in;
   logic        stuff_ff, stuff_in;
   phase_type   phase_ff, phase_in;
   cmd_type     cur_ff, cur_in;
   logic [15:0] crc_ff, crc_in;

   logic [7:0]  phase_byte;
   phase_type   phase_nxt;
   logic        phase_last;
   logic        stuffable;
   logic        crc_phase;
   logic        needs_stuff;
   logic        final_byte;
   logic        emit;
   logic        done;

   always_comb begin
      phase_byte = 8'h00;
      phase_nxt  = phase_ff;
      phase_last = 1'b0;
      stuffable  = 1'b1;
      crc_phase  = 1'b0;
      case (phase_ff)
         PH_PRE0: begin
            phase_byte = cfg.preamble_byte;
            phase_nxt  = PH_PRE1;
            stuffable  = 1'b0;
         end
         PH_PRE1: begin
            phase_byte = cfg.preamble_byte;
            phase_nxt  = PH_PRE2;
            stuffable  = 1'b0;
         end
         PH_PRE2: begin
            phase_byte = cfg.preamble_byte;
            phase_nxt  = PH_SYNC_HI;
            stuffable  = 1'b0;
         end
         PH_SYNC_HI: begin
            phase_byte = cfg.sync_word[15:8];
            phase_nxt  = PH_SYNC_LO;
            stuffable  = 1'b0;
         end
         PH_SYNC_LO: begin
            phase_byte = cfg.sync_word[7:0];
            phase_nxt  = PH_STATUS;
            stuffable  = 1'b0;
         end
         PH_STATUS: begin
            phase_byte = cur_ff.status_byte;
            phase_nxt  = PH_COUNT;
            crc_phase  = 1'b1;
         end
         PH_COUNT: begin
            phase_byte = cur_ff.byte_count;
            phase_nxt  = (cur_ff.byte_count != 8'd0) ? PH_ID : PH_CRC_LO;
            crc_phase  = 1'b1;
         end
         PH_ID: begin
            phase_byte = cur_ff.packet_id;
            phase_last = 1'b1;
            crc_phase  = 1'b1;
         end
         PH_PAYLOAD: begin
            phase_byte = cur_ff.payload_byte;
            phase_nxt  = PH_CRC_LO;
            phase_last = !cur_ff.trailer;
            crc_phase  = 1'b1;
         end
         PH_CRC_LO: begin
            phase_byte = crc_ff[7:0];
            phase_nxt  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            phase_byte = crc_ff[15:8];
            phase_nxt  = PH_ZERO0;
         end
         PH_ZERO0: begin
            phase_byte = 8'h00;
            phase_nxt  = PH_ZERO1;
         end
         PH_ZERO1: begin
            phase_byte = 8'h00;
            phase_last = 1'b1;
         end
         default: begin
            phase_byte = 8'h00;
            phase_last = 1'b1;
         end
      endcase
   end

   // the stuff cycle itself never needs stuffing
   assign needs_stuff = stuffable && !stuff_ff &&
                        ((phase_byte == 8'h00) || (phase_byte == 8'hFF));
   assign final_byte  = phase_last && !needs_stuff;
   assign emit        = busy_ff && !out_full;
   assign done        = emit && final_byte;
   assign cmd_pop     = !cmd_empty && (!busy_ff || done);
   assign out_push    = emit;

   assign out_item.line_byte  = stuff_ff ? cfg.stuff_byte : phase_byte;
   assign out_item.run_last   = final_byte;
   assign out_item.packet_end = final_byte && (phase_ff == PH_ZERO1);

   always_comb begin
      busy_in  = busy_ff;
      stuff_in = stuff_ff;
      phase_in = phase_ff;
      cur_in   = cur_ff;
      crc_in   = crc_ff;
      if (emit && !stuff_ff && crc_phase) begin
         // status opens a fresh CRC
         crc_in = crc_byte((phase_ff == PH_STATUS) ? 16'h0000 : crc_ff, phase_byte);
      end
      if (cmd_pop) begin
         busy_in  = 1'b1;
         cur_in   = cmd;
         stuff_in = 1'b0;
         phase_in = (cmd.op == CMD_START) ? PH_PRE0 : PH_PAYLOAD;
      end else if (done) begin
         busy_in  = 1'b0;
         stuff_in = 1'b0;
      end else if (emit) begin
         if (needs_stuff) begin
            stuff_in = 1'b1;
         end else begin
            stuff_in = 1'b0;
            phase_in = phase_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         stuff_ff <= 1'b0;
         phase_ff <= PH_PRE0;
         crc_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         stuff_ff <= stuff_in;
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// File: hw/rtl/radio_packet_framer_tx.sv
// Top level of the transmit packet framer: CSRs, front end, command queue, back end, output queue.
// Depends on rpf_pkg, rpf_fifo, rpf_front, rpf_back.
//
//   channel   direction  handshake            payload
//   req_      in         push / full          req_item_type (one start or payload item)
//   rsp_      out        pop / empty          rsp_item_type (one line byte)
//   csr_      in         valid / ready        csr_index, csr_wdata
//
// The back end sends one line byte per cycle while the output queue is not full: a payload
// item sends its byte (and a stuff byte when needed), and the trailer adds the CRC and zero bytes;
// a start item sends preamble, sync word and header. The front end takes one item per cycle until
// the command queue fills, so items keep arriving while the back end drains. A full output queue
// stalls only the back end. Reset clears queues, packet state and CRC; CSRs return to defaults.
module radio_packet_framer_tx
   import rpf_pkg::*;
#(
   parameter int CMD_DEPTH = 2,
   parameter int OUT_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_item_type           req_item,
   output logic                   req_full,
   input  logic                   rsp_pop,
   output rsp_item_type           rsp_item,
   output logic                   rsp_empty,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         accept;
   logic         cmd_push, cmd_pop, cmd_full, cmd_empty;
   cmd_type      cmd_wr, cmd_rd;
   logic [$bits(cmd_type)-1:0]      cmd_rd_bits;
   logic         out_push, out_full;
   rsp_item_type out_item;
   logic [$bits(rsp_item_type)-1:0] rsp_bits;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PREAMBLE: cfg_in.preamble_byte = csr_wdata[7:0];
            CSR_SYNC:     cfg_in.sync_word     = csr_wdata;
            CSR_STUFF:    cfg_in.stuff_byte    = csr_wdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_byte <= PREAMBLE_RESET;
         cfg_ff.sync_word     <= SYNC_RESET;
         cfg_ff.stuff_byte    <= STUFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   rpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_item),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   rpf_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd_bits),
      .empty (cmd_empty)
   );

   assign cmd_rd = cmd_type'(cmd_rd_bits);

   rpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   rpf_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_item),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_item = rsp_item_type'(rsp_bits);

endmodule
